// File: design/emmx_pkg.sv
// Package for the extended-MMX SIMD ALU.
// Holds the command codes, lane counts and rounding constant; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package emmx_pkg;

    localparam int BYTE_LANES = 8;
    localparam int WORD_LANES = 4;

    localparam logic signed [31:0] MUL_ROUND = 32'sh0000_4000;

    typedef enum logic [3:0] {
        CMD_AVG   = 4'd0,
        CMD_DIST  = 4'd1,
        CMD_MAG   = 4'd2,
        CMD_MULH  = 4'd3,
        CMD_MULHI = 4'd4,
        CMD_MACH  = 4'd5,
        CMD_MVZ   = 4'd6,
        CMD_MVNZ  = 4'd7,
        CMD_MVLZ  = 4'd8,
        CMD_MVGEZ = 4'd9,
        CMD_ADDSI = 4'd10,
        CMD_SUBSI = 4'd11
    } cmd_t;

endpackage

`default_nettype wire

// File: design/emmx_simd_alu_top.sv
// Top level of the extended-MMX SIMD ALU: eight byte lanes and four word lanes
// feed a lane register, then a merge stage and output register. Depends on
// emmx_pkg, emmx_byte_lane and emmx_word_lane.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   input   | in_valid, in_stall, command, src/dest/implied    | request in
//   output  | out_valid, out_stall, dest_result, implied_result| request out
//
// A result reaches the outputs through the lane register, which loads when its
// request is accepted, and then the output register, which loads as it advances.
// One request per cycle sustained while out_stall is low; the two registers
// each advance on their own, so a request is taken while a result waits.
// in_stall is high only when both stages are full and out_stall is high.
// Reset clears both valid flags; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module emmx_simd_alu_top
    import emmx_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [3:0]  command,
    input  wire  [63:0] src_operand,
    input  wire  [63:0] dest_operand,
    input  wire  [63:0] implied_operand,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [63:0] dest_result,
    output logic [63:0] implied_result
);

    cmd_t        cmd;
    logic [63:0] byte_dest;
    logic [63:0] byte_impl;
    logic [63:0] word_dest;
    logic [63:0] word_impl;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    cmd_t        s1_cmd_reg;
    logic [63:0] s1_byte_dest_reg;
    logic [63:0] s1_byte_impl_reg;
    logic [63:0] s1_word_dest_reg;
    logic [63:0] s1_word_impl_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] dest_result_reg;
    logic [63:0] implied_result_reg;
    logic [63:0] merge_dest;
    logic [63:0] merge_impl;

    logic        s2_adv;
    logic        s1_adv;
    logic        in_take;

    assign cmd = cmd_t'(command);

    genvar gi;
    generate
        for (gi = 0; gi < BYTE_LANES; gi++)
        begin : g_byte
            emmx_byte_lane u_byte_lane (
                .cmd       (cmd),
                .src_byte  (src_operand[8*gi +: 8]),
                .dest_byte (dest_operand[8*gi +: 8]),
                .impl_byte (implied_operand[8*gi +: 8]),
                .dest_out  (byte_dest[8*gi +: 8]),
                .impl_out  (byte_impl[8*gi +: 8])
            );
        end
        for (gi = 0; gi < WORD_LANES; gi++)
        begin : g_word
            emmx_word_lane u_word_lane (
                .cmd       (cmd),
                .src_word  (src_operand[16*gi +: 16]),
                .dest_word (dest_operand[16*gi +: 16]),
                .impl_word (implied_operand[16*gi +: 16]),
                .dest_out  (word_dest[16*gi +: 16]),
                .impl_out  (word_impl[16*gi +: 16])
            );
        end
    endgenerate

    // advance each stage when it is empty or its consumer moves
    assign s2_adv   = !out_valid_reg || !out_stall;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_stall = !s1_adv;
    assign in_take  = in_valid && s1_adv;

    always_comb
    begin
        s1_valid_next  = s1_adv ? in_valid : s1_valid_reg;
        out_valid_next = s2_adv ? s1_valid_reg : out_valid_reg;
    end

    always_comb
    begin
        case (s1_cmd_reg) inside
            CMD_AVG, CMD_DIST, CMD_MVZ, CMD_MVNZ, CMD_MVLZ, CMD_MVGEZ:
            begin
                merge_dest = s1_byte_dest_reg;
                merge_impl = s1_byte_impl_reg;
            end
            default:
            begin
                merge_dest = s1_word_dest_reg;
                merge_impl = s1_word_impl_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg       <= cmd;
            s1_byte_dest_reg <= byte_dest;
            s1_byte_impl_reg <= byte_impl;
            s1_word_dest_reg <= word_dest;
            s1_word_impl_reg <= word_impl;
        end
        if (s2_adv && s1_valid_reg)
        begin
            dest_result_reg    <= merge_dest;
            implied_result_reg <= merge_impl;
        end
    end

    assign out_valid      = out_valid_reg;
    assign dest_result    = dest_result_reg;
    assign implied_result = implied_result_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while a stage had room");

    a_out_from_lane_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a request in the lane stage");

    a_lane_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_cmd_reg)
            && $stable(s1_word_impl_reg) && $stable(s1_byte_dest_reg)))
        else $error("lane stage changed while blocked");

    a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted request was dropped");

endmodule

`default_nettype wire

// File: design/emmx_byte_lane.sv
// One byte lane of the SIMD ALU: average, distance and conditional moves.
// Depends on emmx_pkg for the command codes.
`timescale 1ns / 1ps
`default_nettype none

module emmx_byte_lane
    import emmx_pkg::*;
(
    input  wire cmd_t       cmd,
    input  wire logic [7:0] src_byte,
    input  wire logic [7:0] dest_byte,
    input  wire logic [7:0] impl_byte,
    output logic      [7:0] dest_out,
    output logic      [7:0] impl_out
);

    logic [8:0] avg_sum;
    logic [7:0] diff;
    logic [8:0] dist_sum;

    always_comb
    begin
        avg_sum  = {1'b0, dest_byte} + {1'b0, src_byte};
        diff     = (dest_byte > src_byte) ? (dest_byte - src_byte) : (src_byte - dest_byte);
        dist_sum = {1'b0, impl_byte} + {1'b0, diff};
        dest_out = dest_byte;
        impl_out = impl_byte;
        unique case (cmd)
            CMD_AVG:
            begin
                dest_out = avg_sum[8:1];
            end
            CMD_DIST:
            begin
                impl_out = dist_sum[8] ? 8'hFF : dist_sum[7:0];
            end
            CMD_MVZ:
            begin
                if (impl_byte == 8'h00)
                begin
                    dest_out = src_byte;
                end
            end
            CMD_MVNZ:
            begin
                if (impl_byte != 8'h00)
                begin
                    dest_out = src_byte;
                end
            end
            CMD_MVLZ:
            begin
                if (impl_byte[7])
                begin
                    dest_out = src_byte;
                end
            end
            CMD_MVGEZ:
            begin
                if (!impl_byte[7])
                begin
                    dest_out = src_byte;
                end
            end
            default:
            begin
                dest_out = dest_byte;
                impl_out = impl_byte;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/emmx_word_lane.sv
// One word lane of the SIMD ALU: magnitude select, rounded multiply-high,
// multiply-accumulate and saturating add/subtract. Depends on emmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module emmx_word_lane
    import emmx_pkg::*;
(
    input  wire cmd_t        cmd,
    input  wire logic [15:0] src_word,
    input  wire logic [15:0] dest_word,
    input  wire logic [15:0] impl_word,
    output logic      [15:0] dest_out,
    output logic      [15:0] impl_out
);

    logic signed [31:0] product;
    logic signed [31:0] rounded;
    logic        [15:0] mul_hi;
    logic        [16:0] dest_mag;
    logic        [16:0] src_mag;
    logic signed [16:0] add_sum;
    logic signed [16:0] sub_diff;
    logic        [15:0] add_sat;
    logic        [15:0] sub_sat;

    always_comb
    begin
        product  = 32'($signed(dest_word)) * 32'($signed(src_word));
        rounded  = product + MUL_ROUND;
        mul_hi   = rounded[30:15];
        dest_mag = dest_word[15] ? (17'd0 - {1'b1, dest_word}) : {1'b0, dest_word};
        src_mag  = src_word[15] ? (17'd0 - {1'b1, src_word}) : {1'b0, src_word};
        add_sum  = {dest_word[15], dest_word} + {src_word[15], src_word};
        sub_diff = {dest_word[15], dest_word} - {src_word[15], src_word};
        if (add_sum[16] != add_sum[15])
        begin
            add_sat = add_sum[16] ? 16'h8000 : 16'h7FFF;
        end
        else
        begin
            add_sat = add_sum[15:0];
        end
        if (sub_diff[16] != sub_diff[15])
        begin
            sub_sat = sub_diff[16] ? 16'h8000 : 16'h7FFF;
        end
        else
        begin
            sub_sat = sub_diff[15:0];
        end
    end

    always_comb
    begin
        dest_out = dest_word;
        impl_out = impl_word;
        unique case (cmd)
            CMD_MAG:
            begin
                if (dest_mag > src_mag)
                begin
                    dest_out = src_word;
                end
            end
            CMD_MULH:
            begin
                dest_out = mul_hi;
            end
            CMD_MULHI:
            begin
                impl_out = mul_hi;
            end
            CMD_MACH:
            begin
                impl_out = impl_word + mul_hi;
            end
            CMD_ADDSI:
            begin
                impl_out = add_sat;
            end
            CMD_SUBSI:
            begin
                impl_out = sub_sat;
            end
            default:
            begin
                dest_out = dest_word;
                impl_out = impl_word;
            end
        endcase
    end

endmodule

`default_nettype wire
